// ===== src/fbd_pkg.sv =====
// fbd_pkg: shared types, codes and constants of the LDPC frame buffer derandomizer.
// No dependencies; compiled first.
package fbd_pkg;

	localparam int FUNC_W      = 2;
	localparam int FRAME_W     = 14;
	localparam int MODE_W      = 2;
	localparam int POS_W       = 16;
	localparam int CFG_INDEX_W = 1;
	localparam int CFG_DATA_W  = 14;
	localparam int LFSR_W      = 8;
	localparam int IRIG_W      = 15;
	localparam int DEPTH_RAW_W = 12;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = 1;
	localparam int QCNT_W      = 2;

	// request function codes
	localparam logic [FUNC_W-1:0] FUNC_IDLE    = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_WRITE   = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_RESTART = 2'd2;

	// derandomizer modes; the fourth code stores symbols unchanged
	localparam logic [MODE_W-1:0] DM_NONE  = 2'd0;
	localparam logic [MODE_W-1:0] DM_CCSDS = 2'd1;
	localparam logic [MODE_W-1:0] DM_IRIG  = 2'd2;

	// configuration register indexes
	localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_BITS  = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_DERAND_MODE = 1'd1;

	localparam logic [FRAME_W-1:0]      FRAME_BITS_RST = 14'd8192;
	localparam logic [LFSR_W-1:0]       LFSR_SEED      = 8'hFF;
	localparam logic [IRIG_W-1:0]       IRIG_SEED      = 15'd3;
	localparam logic signed [POS_W-1:0] POS_RST        = -16'sd1;
	localparam logic signed [POS_W-1:0] POS_MAX        = 16'sd32767;
	localparam logic [DEPTH_RAW_W-1:0]  DEPTH_DEFAULT  = 12'd128;

	typedef enum logic [1:0] {
		OP_NOP,
		OP_WRITE,
		OP_RESTART
	} op_t;

	// classified request as it sits in the queue (sample travels beside it)
	typedef struct packed {
		op_t  op;
		logic out_side;
		logic done_a;
		logic done_b;
		logic ready_a;
		logic ready_b;
	} ctrl_t;

	typedef struct packed {
		logic [QCNT_W-1:0] count;
		logic              full;
		logic              empty;
	} qstat_t;

	// per-bank depth for a given frame length, before the depth cap
	function automatic logic [DEPTH_RAW_W-1:0] depth_raw(input logic [FRAME_W-1:0] n);
		logic [DEPTH_RAW_W-1:0] d;
		unique case (n)
			14'd2048, 14'd5120: d = 12'd512;
			14'd1536:           d = 12'd256;
			14'd6144:           d = 12'd1024;
			14'd8192:           d = 12'd2048;
			default:            d = DEPTH_DEFAULT;
		endcase
		return d;
	endfunction

endpackage

// ===== src/fbd_ifs.sv =====
// fbd_ifs: valid/ready channel interfaces for symbol requests, results and config writes.
// Depends on fbd_pkg.
interface fbd_sym_if #(
	parameter int SAMPLE_BITS = 8
);
	logic                          valid;
	logic                          ready;
	logic [fbd_pkg::FUNC_W-1:0]    func;
	logic signed [SAMPLE_BITS-1:0] sample;
	logic                          out_side;
	logic                          done_a;
	logic                          done_b;
	logic                          ready_a;
	logic                          ready_b;

	modport source (output valid, func, sample, out_side, done_a, done_b, ready_a, ready_b,
		input ready);
	modport sink (input valid, func, sample, out_side, done_a, done_b, ready_a, ready_b,
		output ready);
endinterface

interface fbd_res_if #(
	parameter int SAMPLE_BITS = 8,
	parameter int BANK_W      = 4,
	parameter int OFF_W       = 11
);
	logic                              valid;
	logic                              ready;
	logic signed [SAMPLE_BITS-1:0]     sample_out;
	logic                              mem_write;
	logic [BANK_W-1:0]                 bank;
	logic [OFF_W-1:0]                  bank_offset;
	logic signed [fbd_pkg::POS_W-1:0]  write_position;
	logic                              frame_full;
	logic                              overrun;
	logic                              start_a;
	logic                              start_b;
	logic                              buffer_side;

	modport source (output valid, sample_out, mem_write, bank, bank_offset, write_position,
		frame_full, overrun, start_a, start_b, buffer_side, input ready);
	modport sink (input valid, sample_out, mem_write, bank, bank_offset, write_position,
		frame_full, overrun, start_a, start_b, buffer_side, output ready);
endinterface

interface fbd_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [fbd_pkg::CFG_INDEX_W-1:0] index;
	logic [fbd_pkg::CFG_DATA_W-1:0]  data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== src/ldpc_frame_buffer_derandomizer.sv =====
// A request accepted by the front is written into the queue and then executed into the result
// register; throughput is one request per cycle while results are drained (results.ready high),
// with the counters and derandomizer state in fbd_back updated once per popped request.
// Reset (arst_n low, asynchronous): queue empty, no result pending, position -1,
// counters 0, bank depth 128, LFSR 0xFF, PN register 3, all flags low, frame_bits 8192,
// derand_mode 0. No clearing pass; requests are taken right after reset.
module ldpc_frame_buffer_derandomizer #(
	parameter int BANK_COUNT     = 11,
	parameter int MAX_BANK_DEPTH = 2048,
	parameter int SAMPLE_BITS    = 8
) (
	input  logic     clk,
	input  logic     arst_n,
	fbd_sym_if.sink  symbols,
	fbd_res_if.source results,
	fbd_cfg_if.sink  cfg
);

	localparam int DATA_W = $bits(fbd_pkg::ctrl_t) + SAMPLE_BITS;

	// configuration registers; to be written only while no request is in flight (user's duty, not enforced)
	logic [fbd_pkg::FRAME_W-1:0] frame_bits_q;
	logic [fbd_pkg::MODE_W-1:0]  derand_mode_q;

	// front-to-back queue
	logic              push;
	logic              pop;
	logic [DATA_W-1:0] entry;
	logic [DATA_W-1:0] head;
	fbd_pkg::qstat_t   q_stat;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_bits_q  <= fbd_pkg::FRAME_BITS_RST;
			derand_mode_q <= fbd_pkg::DM_NONE;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				fbd_pkg::CFG_FRAME_BITS:  frame_bits_q  <= cfg.data[fbd_pkg::FRAME_W-1:0];
				fbd_pkg::CFG_DERAND_MODE: derand_mode_q <= cfg.data[fbd_pkg::MODE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// front: takes a request whenever the queue has room, decodes func
	fbd_front #(
		.SAMPLE_BITS (SAMPLE_BITS),
		.DATA_W      (DATA_W)
	) u_front (
		.symbols (symbols),
		.q_stat  (q_stat),
		.push    (push),
		.entry   (entry)
	);

	// two entries decouple request intake from result back-pressure
	fbd_queue #(
		.DATA_W (DATA_W)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.entry  (entry),
		.pop    (pop),
		.head   (head),
		.q_stat (q_stat)
	);

	// back: pops when the result register is free or being drained
	fbd_back #(
		.BANK_COUNT     (BANK_COUNT),
		.MAX_BANK_DEPTH (MAX_BANK_DEPTH),
		.SAMPLE_BITS    (SAMPLE_BITS),
		.DATA_W         (DATA_W)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.frame_bits  (frame_bits_q),
		.derand_mode (derand_mode_q),
		.q_stat      (q_stat),
		.head        (head),
		.pop         (pop),
		.results     (results)
	);

	// queue occupancy tracks a push that is not matched by a pop
	a_queue_count: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> q_stat.count == $past(q_stat.count) + 2'd1)
		else $error("queue count did not follow push");

	// overrun is only ever raised together with full and cleared with it
	a_overrun_full: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && results.overrun |-> results.frame_full)
		else $error("overrun without frame_full");

	// writes stay inside the bank array
	a_bank_range: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && results.mem_write |-> 32'(results.bank) < BANK_COUNT)
		else $error("bank write beyond last bank");

endmodule

// ===== src/fbd_front.sv =====
// fbd_front: accepts symbol requests, decodes the function code, pushes into the queue.
// Depends on fbd_pkg and fbd_sym_if.
module fbd_front #(
	parameter int SAMPLE_BITS = 8,
	parameter int DATA_W      = $bits(fbd_pkg::ctrl_t) + SAMPLE_BITS
) (
	fbd_sym_if.sink           symbols,
	input  fbd_pkg::qstat_t   q_stat,
	output logic              push,
	output logic [DATA_W-1:0] entry
);

	fbd_pkg::ctrl_t ctrl;

	assign symbols.ready = !q_stat.full;
	assign push          = symbols.valid && !q_stat.full;

	always_comb begin
		unique case (symbols.func)
			fbd_pkg::FUNC_WRITE:   ctrl.op = fbd_pkg::OP_WRITE;
			fbd_pkg::FUNC_RESTART: ctrl.op = fbd_pkg::OP_RESTART;
			default:               ctrl.op = fbd_pkg::OP_NOP;	// idle and spare code
		endcase
		ctrl.out_side = symbols.out_side;
		ctrl.done_a   = symbols.done_a;
		ctrl.done_b   = symbols.done_b;
		ctrl.ready_a  = symbols.ready_a;
		ctrl.ready_b  = symbols.ready_b;
	end

	assign entry = {ctrl, symbols.sample};

endmodule

// ===== src/fbd_queue.sv =====
// fbd_queue: two-entry FIFO between request decode and execution.
// Depends on fbd_pkg.
module fbd_queue #(
	parameter int DATA_W = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic [DATA_W-1:0] entry,
	input  logic              pop,
	output logic [DATA_W-1:0] head,
	output fbd_pkg::qstat_t   q_stat
);

	logic [DATA_W-1:0]              mem_q [fbd_pkg::QUEUE_DEPTH];
	logic [fbd_pkg::QPTR_W-1:0]     wr_ptr_q;
	logic [fbd_pkg::QPTR_W-1:0]     rd_ptr_q;
	logic [fbd_pkg::QCNT_W-1:0]     count_q;
	logic                           do_push;
	logic                           do_pop;

	assign q_stat.count = count_q;
	assign q_stat.full  = (count_q == fbd_pkg::QCNT_W'(fbd_pkg::QUEUE_DEPTH));
	assign q_stat.empty = (count_q == '0);
	assign do_push      = push && !q_stat.full;
	assign do_pop       = pop && !q_stat.empty;
	assign head         = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== src/fbd_back.sv =====
// fbd_back: executes queued requests - derandomizer, bank/offset counters, frame flags -
// and holds the result register. Depends on fbd_pkg and fbd_res_if.
module fbd_back #(
	parameter int BANK_COUNT     = 11,
	parameter int MAX_BANK_DEPTH = 2048,
	parameter int SAMPLE_BITS    = 8,
	parameter int DATA_W         = $bits(fbd_pkg::ctrl_t) + SAMPLE_BITS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [fbd_pkg::FRAME_W-1:0] frame_bits,
	input  logic [fbd_pkg::MODE_W-1:0]  derand_mode,
	input  fbd_pkg::qstat_t             q_stat,
	input  logic [DATA_W-1:0]           head,
	output logic                        pop,
	fbd_res_if.source                   results
);

	localparam int CTRL_W     = $bits(fbd_pkg::ctrl_t);
	localparam int BANK_W     = (BANK_COUNT > 1) ? $clog2(BANK_COUNT) : 1;
	localparam int BANK_CNT_W = $clog2(BANK_COUNT + 1);
	localparam int OFF_W      = $clog2(MAX_BANK_DEPTH);
	localparam int OFF_CNT_W  = $clog2(MAX_BANK_DEPTH + 1);
	localparam int POS_W      = fbd_pkg::POS_W;

	fbd_pkg::ctrl_t                ctrl;
	logic [SAMPLE_BITS-1:0]        s;

	// execution state
	logic signed [POS_W-1:0]           pos_q, pos_d;
	logic [OFF_CNT_W-1:0]              off_q, off_d, off_inc;
	logic [BANK_CNT_W-1:0]             bank_q, bank_d;
	logic [OFF_CNT_W-1:0]              depth_q, depth_d;
	logic [fbd_pkg::LFSR_W-1:0]        lfsr_q, lfsr_d;
	logic [fbd_pkg::IRIG_W-1:0]        irig_q, irig_d;
	logic                              side_q, side_d;
	logic                              full_q, full_d;
	logic                              overrun_q, overrun_d;
	logic                              start_a_q, start_a_d;
	logic                              start_b_q, start_b_d;
	logic [SAMPLE_BITS-1:0]            last_q, last_d;

	// per-request result fields
	logic                              res_valid_q;
	logic                              wr_q, wr_d;
	logic [BANK_W-1:0]                 wbank_q, wbank_d;
	logic [OFF_W-1:0]                  woff_q, woff_d;

	logic signed [POS_W-1:0]           pos_inc;
	logic [fbd_pkg::DEPTH_RAW_W-1:0]   raw_depth;
	logic [OFF_CNT_W-1:0]              new_depth;
	logic                              neg;
	logic                              lfsr_fb;
	logic                              frame_end;

	assign ctrl = fbd_pkg::ctrl_t'(head[DATA_W-1 -: CTRL_W]);
	assign s    = head[SAMPLE_BITS-1:0];
	assign pop  = !q_stat.empty && (!res_valid_q || results.ready);

	assign raw_depth = fbd_pkg::depth_raw(frame_bits);
	assign new_depth = (32'(raw_depth) > MAX_BANK_DEPTH) ? OFF_CNT_W'(MAX_BANK_DEPTH)
		: OFF_CNT_W'(raw_depth);

	assign pos_inc   = (pos_q == fbd_pkg::POS_MAX) ? pos_q : pos_q + POS_W'(1);
	// position is never negative after a write, so compare as unsigned with one extra bit
	assign frame_end = (({1'b0, pos_inc} + (POS_W + 1)'(1)) == (POS_W + 1)'(frame_bits));
	assign off_inc   = off_q + 1'b1;
	assign lfsr_fb   = lfsr_q[0] ^ lfsr_q[3] ^ lfsr_q[5] ^ lfsr_q[7];

	always_comb begin
		pos_d     = pos_q;
		off_d     = off_q;
		bank_d    = bank_q;
		depth_d   = depth_q;
		lfsr_d    = lfsr_q;
		irig_d    = irig_q;
		side_d    = side_q;
		full_d    = full_q;
		overrun_d = overrun_q;
		start_a_d = start_a_q;
		start_b_d = start_b_q;
		last_d    = last_q;
		wr_d      = 1'b0;
		wbank_d   = '0;
		woff_d    = '0;
		neg       = 1'b0;

		unique case (ctrl.op)
			fbd_pkg::OP_RESTART: begin
				pos_d     = fbd_pkg::POS_RST;
				off_d     = '0;
				bank_d    = '0;
				depth_d   = new_depth;
				lfsr_d    = fbd_pkg::LFSR_SEED;
				full_d    = 1'b0;
				overrun_d = 1'b0;
				side_d    = ctrl.out_side;
			end
			fbd_pkg::OP_WRITE: begin
				pos_d = pos_inc;
				if (derand_mode == fbd_pkg::DM_CCSDS) begin
					neg    = lfsr_q[0];
					lfsr_d = {lfsr_fb, lfsr_q[fbd_pkg::LFSR_W-1:1]};
				end else if (derand_mode == fbd_pkg::DM_IRIG) begin
					// self-synchronizing: shift in the received sign
					neg    = irig_q[13] ^ irig_q[14];
					irig_d = {irig_q[fbd_pkg::IRIG_W-2:0], s[SAMPLE_BITS-1]};
				end
				last_d = neg ? SAMPLE_BITS'(~s + 1'b1) : s;	// most negative wraps

				if (bank_q < BANK_CNT_W'(BANK_COUNT)) begin
					wr_d    = 1'b1;
					wbank_d = BANK_W'(bank_q);
					woff_d  = OFF_W'(off_q);
					if (off_inc >= depth_q) begin
						off_d  = '0;
						bank_d = bank_q + 1'b1;
					end else begin
						off_d = off_inc;
					end
				end

				if (frame_end) begin
					full_d = 1'b1;
					if (!side_q) begin
						start_a_d = 1'b1;
						if (!ctrl.done_b) overrun_d = 1'b1;
					end else begin
						start_b_d = 1'b1;
						if (!ctrl.done_a) overrun_d = 1'b1;
					end
				end
			end
			default: begin
			end
		endcase

		// decoder handshake wins over a start raised in the same request
		if (ctrl.ready_a) start_a_d = 1'b0;
		if (ctrl.ready_b) start_b_d = 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
			pos_q       <= fbd_pkg::POS_RST;
			off_q       <= '0;
			bank_q      <= '0;
			depth_q     <= OFF_CNT_W'(fbd_pkg::DEPTH_DEFAULT);
			lfsr_q      <= fbd_pkg::LFSR_SEED;
			irig_q      <= fbd_pkg::IRIG_SEED;
			side_q      <= 1'b0;
			full_q      <= 1'b0;
			overrun_q   <= 1'b0;
			start_a_q   <= 1'b0;
			start_b_q   <= 1'b0;
			last_q      <= '0;
		end else begin
			if (pop) begin
				res_valid_q <= 1'b1;
				pos_q       <= pos_d;
				off_q       <= off_d;
				bank_q      <= bank_d;
				depth_q     <= depth_d;
				lfsr_q      <= lfsr_d;
				irig_q      <= irig_d;
				side_q      <= side_d;
				full_q      <= full_d;
				overrun_q   <= overrun_d;
				start_a_q   <= start_a_d;
				start_b_q   <= start_b_d;
				last_q      <= last_d;
			end else if (results.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			wr_q    <= wr_d;
			wbank_q <= wbank_d;
			woff_q  <= woff_d;
		end
	end

	assign results.valid          = res_valid_q;
	assign results.sample_out     = last_q;
	assign results.mem_write      = wr_q;
	assign results.bank           = wbank_q;
	assign results.bank_offset    = woff_q;
	assign results.write_position = pos_q;
	assign results.frame_full     = full_q;
	assign results.overrun        = overrun_q;
	assign results.start_a        = start_a_q;
	assign results.start_b        = start_b_q;
	assign results.buffer_side    = side_q;

endmodule
